// File: src/tcld_pkg.sv
// Package with the shared types, constants and pattern tables of the command line decoder.
`timescale 1ns / 1ps
package tcld_pkg;

  localparam int unsigned LINE_LENGTH = 20;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned PAT_COUNT   = 7;
  localparam int unsigned PAT_MAX_LEN = 14;

  localparam logic [2:0] PAT_CONNECTED = 3'd0;
  localparam logic [2:0] PAT_CONN_END  = 3'd1;
  localparam logic [2:0] PAT_MLDP      = 3'd2;
  localparam logic [2:0] PAT_CMD       = 3'd3;
  localparam logic [2:0] PAT_END       = 3'd4;
  localparam logic [2:0] PAT_ON        = 3'd5;
  localparam logic [2:0] PAT_OFF       = 3'd6;

  localparam logic [POS_W-1:0] ON_DIGIT_POS  = 5'd6;
  localparam logic [POS_W-1:0] OFF_DIGIT_POS = 5'd7;

  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_TWO   = 8'h32;
  localparam logic [7:0] CHAR_THREE = 8'h33;
  localparam logic [7:0] FOLD_LOW   = 8'd91;
  localparam logic [7:0] FOLD_HIGH  = 8'd127;
  localparam logic [7:0] FOLD_DELTA = 8'd32;

  // Register indexes (byte address / 4).
  localparam logic [1:0] REG_CMD_MASK  = 2'd0;
  localparam logic [1:0] REG_LED_ONE   = 2'd1;
  localparam logic [1:0] REG_LED_TWO   = 2'd2;
  localparam logic [1:0] REG_LED_THREE = 2'd3;

  localparam logic [7:0] CMD_MASK_RST  = 8'd1;
  localparam logic [7:0] LED_ONE_RST   = 8'd2;
  localparam logic [7:0] LED_TWO_RST   = 8'd4;
  localparam logic [7:0] LED_THREE_RST = 8'd8;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  typedef struct packed {
    logic [7:0] cmd_mask;
    logic [7:0] led_one_bits;
    logic [7:0] led_two_bits;
    logic [7:0] led_three_bits;
  } masks_t;

  typedef struct packed {
    logic [7:0] pin_state;
    logic       is_connected;
    logic       in_data_mode;
    logic       line_done;
  } result_t;

  function automatic logic [4:0] pat_len(input logic [2:0] k);
    logic [4:0] len;
    case (k)
      PAT_CONNECTED: len = 5'd9;
      PAT_CONN_END:  len = 5'd14;
      PAT_MLDP:      len = 5'd4;
      PAT_CMD:       len = 5'd3;
      PAT_END:       len = 5'd3;
      PAT_ON:        len = 5'd6;
      PAT_OFF:       len = 5'd7;
      default:       len = 5'd0;
    endcase
    return len;
  endfunction

  // Character idx of pattern k; the text is left-justified in a 14-byte word.
  function automatic logic [7:0] pat_char(input logic [2:0] k, input logic [3:0] idx);
    logic [8*PAT_MAX_LEN-1:0] txt;
    case (k)
      PAT_CONNECTED: txt = {"CONNECTED", 40'h0};
      PAT_CONN_END:  txt = "CONNECTION END";
      PAT_MLDP:      txt = {"MLDP", 80'h0};
      PAT_CMD:       txt = {"CMD", 88'h0};
      PAT_END:       txt = {"END", 88'h0};
      PAT_ON:        txt = {"ON,LED", 64'h0};
      PAT_OFF:       txt = {"OFF,LED", 56'h0};
      default:       txt = '0;
    endcase
    return txt[8*(PAT_MAX_LEN-1-idx) +: 8];
  endfunction

  function automatic logic [7:0] led_mask_for(input masks_t m, input logic [7:0] digit);
    logic [7:0] mask;
    case (digit)
      CHAR_ONE:   mask = m.led_one_bits;
      CHAR_TWO:   mask = m.led_two_bits;
      CHAR_THREE: mask = m.led_three_bits;
      default:    mask = 8'd0;
    endcase
    return mask;
  endfunction

endpackage

// File: src/tcld_if.sv
// Valid/ready channel interfaces for received bytes and decoder results.
`timescale 1ns / 1ps
interface tcld_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface tcld_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] pin_state;
  logic       is_connected;
  logic       in_data_mode;
  logic       line_done;

  modport source (output valid, output pin_state, output is_connected,
                  output in_data_mode, output line_done, input ready);
  modport sink (input valid, input pin_state, input is_connected,
                input in_data_mode, input line_done, output ready);
endinterface

// File: src/tcld_cfg.sv
// APB register bank holding the command and LED pin masks.
`timescale 1ns / 1ps
module tcld_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tcld_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [tcld_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [tcld_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output tcld_pkg::masks_t                    masks
);

  logic       wr_en;
  logic [1:0] reg_idx;
  logic [7:0] rd_byte;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      masks.cmd_mask       <= tcld_pkg::CMD_MASK_RST;
      masks.led_one_bits   <= tcld_pkg::LED_ONE_RST;
      masks.led_two_bits   <= tcld_pkg::LED_TWO_RST;
      masks.led_three_bits <= tcld_pkg::LED_THREE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        tcld_pkg::REG_CMD_MASK:  masks.cmd_mask       <= pwdata[7:0];
        tcld_pkg::REG_LED_ONE:   masks.led_one_bits   <= pwdata[7:0];
        tcld_pkg::REG_LED_TWO:   masks.led_two_bits   <= pwdata[7:0];
        tcld_pkg::REG_LED_THREE: masks.led_three_bits <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tcld_pkg::REG_CMD_MASK:  rd_byte = masks.cmd_mask;
      tcld_pkg::REG_LED_ONE:   rd_byte = masks.led_one_bits;
      tcld_pkg::REG_LED_TWO:   rd_byte = masks.led_two_bits;
      tcld_pkg::REG_LED_THREE: rd_byte = masks.led_three_bits;
      default:                 rd_byte = 8'd0;
    endcase
  end

  assign prdata = {{(tcld_pkg::APB_DATA_W-8){1'b0}}, rd_byte};

endmodule

// File: src/tcld_line.sv
// Line state, running prefix matchers and command execution for one byte per cycle in which step is high.
`timescale 1ns / 1ps
module tcld_line #(
  parameter int unsigned LINE_LENGTH = tcld_pkg::LINE_LENGTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  tcld_pkg::masks_t  masks,
  output tcld_pkg::result_t result
);

  localparam logic [tcld_pkg::POS_W-1:0] POS_LIMIT = tcld_pkg::POS_W'(LINE_LENGTH - 1);

  logic [tcld_pkg::POS_W-1:0]     line_position, line_position_next;
  logic [tcld_pkg::PAT_COUNT-1:0] matching, matching_next, match_base, match_keep;
  logic [7:0]                     on_digit, on_digit_next;
  logic [7:0]                     off_digit, off_digit_next;
  logic                           connected, connected_next;
  logic                           data_mode, data_mode_next;
  logic [7:0]                     pins, pins_next;
  logic [7:0]                     folded;
  logic                           pos_ok;
  logic                           line_end;

  assign pos_ok = line_position < POS_LIMIT;
  assign folded = (rx_byte >= tcld_pkg::FOLD_LOW && rx_byte <= tcld_pkg::FOLD_HIGH) ?
                  rx_byte - tcld_pkg::FOLD_DELTA : rx_byte;
  assign line_end = pos_ok && (folded == tcld_pkg::CHAR_LF || folded == tcld_pkg::CHAR_CR);
  assign match_base = (line_position == '0) ? '1 : matching;

  // Each pattern keeps its flag while the byte at this position agrees with it or lies past its end.
  always_comb begin
    for (int k = 0; k < tcld_pkg::PAT_COUNT; k++) begin
      match_keep[k] = match_base[k] &
                      ((line_position >= tcld_pkg::pat_len(3'(k))) ||
                       (folded == tcld_pkg::pat_char(3'(k), line_position[3:0])));
    end
  end

  always_comb begin
    matching_next      = matching;
    on_digit_next      = on_digit;
    off_digit_next     = off_digit;
    line_position_next = '0;
    if (pos_ok) begin
      matching_next = match_keep;
      if (line_position == tcld_pkg::ON_DIGIT_POS) on_digit_next = folded;
      if (line_position == tcld_pkg::OFF_DIGIT_POS) off_digit_next = folded;
      if (!line_end) line_position_next = line_position + 1'b1;
    end
  end

  // The first matching command whose condition holds wins.
  always_comb begin
    connected_next = connected;
    data_mode_next = data_mode;
    pins_next      = pins;
    if (line_end) begin
      if (match_keep[tcld_pkg::PAT_CONNECTED]) begin
        connected_next = 1'b1;
        data_mode_next = 1'b1;
        pins_next      = pins | masks.cmd_mask;
      end else if (match_keep[tcld_pkg::PAT_CONN_END]) begin
        connected_next = 1'b0;
        data_mode_next = 1'b0;
        pins_next      = pins & ~masks.cmd_mask;
      end else if (match_keep[tcld_pkg::PAT_MLDP] && connected && !data_mode) begin
        data_mode_next = 1'b1;
        pins_next      = pins | masks.cmd_mask;
      end else if ((match_keep[tcld_pkg::PAT_CMD] || match_keep[tcld_pkg::PAT_END]) &&
                   connected && data_mode) begin
        data_mode_next = 1'b0;
        pins_next      = pins & ~masks.cmd_mask;
      end else if (match_keep[tcld_pkg::PAT_ON] && connected && data_mode) begin
        pins_next = pins | tcld_pkg::led_mask_for(masks, on_digit_next);
      end else if (match_keep[tcld_pkg::PAT_OFF]) begin
        pins_next = pins & ~tcld_pkg::led_mask_for(masks, off_digit_next);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_position <= '0;
      matching      <= '1;
      on_digit      <= '0;
      off_digit     <= '0;
      connected     <= 1'b0;
      data_mode     <= 1'b0;
      pins          <= '0;
    end else if (step) begin
      line_position <= line_position_next;
      matching      <= matching_next;
      on_digit      <= on_digit_next;
      off_digit     <= off_digit_next;
      connected     <= connected_next;
      data_mode     <= data_mode_next;
      pins          <= pins_next;
    end
  end

  assign result.pin_state    = pins_next;
  assign result.is_connected = connected_next;
  assign result.in_data_mode = data_mode_next;
  assign result.line_done    = line_end;

endmodule

// File: src/text_command_line_decoder_core.sv
// Top level of the text command line decoder: input register, line logic, result register.
`timescale 1ns / 1ps
// How to use this block:
// Received characters enter on rx_ch, one byte per transfer. Every byte gives
// exactly one transfer on res_ch carrying the pin byte, the connected and data
// mode flags after that byte, and line_done, which is set when the byte was a
// CR or LF that closed a line and the command search ran.
// A byte is captured into an input register; when it moves on, the prefix
// matchers and command logic update the line state and load the result
// register, and res_ch.valid rises. Throughput is one byte per cycle while
// the receiver keeps ready high, limited by the state update in the line
// logic. The input side keeps accepting while a result waits, as long as
// the input register is empty, or the result register is empty or being
// taken in that cycle; when the receiver holds ready low, the input
// register and then rx_ch.ready stall, and no result is lost or repeated.
// The pin masks are written through the APB port, at byte address 4*i; the
// user must write them only while no byte is in flight, which the block
// does not enforce. Synchronous reset empties both registers, clears the
// line, the flags and the pins, and restores the default masks (command pin
// bit 0, LEDs on bits 1 to 3). No clearing pass follows reset.
module text_command_line_decoder_core #(
  parameter int unsigned LINE_LENGTH = tcld_pkg::LINE_LENGTH
) (
  input  logic                            clk,
  input  logic                            rst,
  tcld_rx_if.sink                         rx_ch,
  tcld_res_if.source                      res_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tcld_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tcld_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tcld_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  tcld_pkg::masks_t  masks;
  tcld_pkg::result_t line_result;
  tcld_pkg::result_t res_data;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_adv;
  logic       res_valid;

  tcld_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .masks   (masks)
  );

  // The stored byte moves on when the result register is free or being drained.
  assign s1_adv      = s1_valid && (!res_valid || res_ch.ready);
  assign rx_ch.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx_ch.ready) begin
      s1_valid <= rx_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_ch.valid && rx_ch.ready) begin
      s1_byte <= rx_ch.rx_byte;
    end
  end

  tcld_line #(
    .LINE_LENGTH (LINE_LENGTH)
  ) u_line (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_adv),
    .rx_byte (s1_byte),
    .masks   (masks),
    .result  (line_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= 1'b1;
    end else if (res_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_data <= line_result;
    end
  end

  assign res_ch.valid        = res_valid;
  assign res_ch.pin_state    = res_data.pin_state;
  assign res_ch.is_connected = res_data.is_connected;
  assign res_ch.in_data_mode = res_data.in_data_mode;
  assign res_ch.line_done    = res_data.line_done;

  // An empty result register never blocks the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> rx_ch.ready)
    else $error("input stalled while the result register was empty");

  // Every byte that leaves the input register shows up as a result.
  a_step_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> res_valid)
    else $error("processed byte produced no result");

  // Data mode is only ever entered while connected, and leaving the link ends it.
  a_data_mode_needs_link: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.in_data_mode |-> res_data.is_connected)
    else $error("data mode reported without a connection");

endmodule

// File: tb/sv/tb_text_command_line_decoder_core.sv
// Self-checking testbench for the text command line decoder core.
`timescale 1ns / 1ps
module tb_text_command_line_decoder_core;
  import tcld_pkg::*;

  // The receiver holds ready low this long in the backpressure test. That is
  // long enough for both internal registers to fill and the input to stall.
  localparam int HOLD_CYCLES   = 300;
  // The watchdog gives up after this many cycles without any transfer. This
  // is several times the longest correct quiet stretch, which is the hold.
  localparam int STALL_LIMIT   = 2000;
  // The input and result registers hold anything in flight; this wait covers them.
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 10;
  localparam int PHASE_ITEMS   = 100;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  tcld_rx_if  rx_ch ();
  tcld_res_if res_ch ();

  text_command_line_decoder_core DUT (
    .clk     (clk),
    .rst     (rst),
    .rx_ch   (rx_ch),
    .res_ch  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // The command texts, listed in the order of the pattern indexes of the
  // package. That order is also the priority of the command search.
  string line_pattern [PAT_COUNT] = '{"CONNECTED", "CONNECTION END", "MLDP",
                                      "CMD", "END", "ON,LED", "OFF,LED"};

  // Predictor state. This is our own copy of the line and link state and of
  // the pin masks as they should stand inside the block.
  masks_t      cur_masks     = '{CMD_MASK_RST, LED_ONE_RST, LED_TWO_RST, LED_THREE_RST};
  logic [4:0]  line_fill     = '0;
  logic [6:0]  prefix_alive  = '1;
  logic [7:0]  on_digit_seen = '0;
  logic [7:0]  off_digit_seen = '0;
  logic        link_up       = 1'b0;
  logic        data_mode     = 1'b0;
  logic [7:0]  pins          = '0;

  // Results the block still owes us, oldest first.
  result_t expected_pin_reports [$];

  int  error_count   = 0;
  int  sent_count    = 0;
  int  hold_requests = 0;
  bit  src_idle_on   = 1'b1;
  bit  sink_idle_on  = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Returns the pin bits that belong to an LED digit. Any byte other than
  // '1', '2' or '3' selects no pins at all.
  function automatic logic [7:0] led_bits_for_digit(input logic [7:0] digit);
    logic [7:0] bits;
    case (digit)
      CHAR_ONE:   bits = cur_masks.led_one_bits;
      CHAR_TWO:   bits = cur_masks.led_two_bits;
      CHAR_THREE: bits = cur_masks.led_three_bits;
      default:    bits = 8'd0;
    endcase
    return bits;
  endfunction

  // Advances the predictor by one received byte and returns the result the
  // block has to report for it.
  function automatic result_t decode_rx_byte(input logic [7:0] raw);
    logic [7:0] ch;
    logic [4:0] pos;
    result_t    res;
    int         k;
    ch = raw;
    pos = line_fill;
    res.line_done = 1'b0;
    if (pos < LINE_LENGTH - 1) begin
      // Bytes from 91 to 127 are folded down by 32, so lower case matches.
      if (ch >= FOLD_LOW && ch <= FOLD_HIGH) ch = ch - FOLD_DELTA;
      if (pos == 0) prefix_alive = '1;
      // A pattern stays alive only while every stored byte matches it. Bytes
      // past the end of a pattern do not touch its flag.
      for (k = 0; k < PAT_COUNT; k++) begin
        if (pos < line_pattern[k].len() && ch != line_pattern[k][pos])
          prefix_alive[k] = 1'b0;
      end
      if (pos == ON_DIGIT_POS) on_digit_seen = ch;
      if (pos == OFF_DIGIT_POS) off_digit_seen = ch;
      line_fill = pos + 5'd1;
      if (ch == CHAR_LF || ch == CHAR_CR) begin
        line_fill = '0;
        res.line_done = 1'b1;
        // The first live pattern whose condition holds wins. A live ON,LED
        // with a bad digit still wins and changes nothing.
        if (prefix_alive[PAT_CONNECTED]) begin
          link_up = 1'b1;
          data_mode = 1'b1;
          pins = pins | cur_masks.cmd_mask;
        end else if (prefix_alive[PAT_CONN_END]) begin
          link_up = 1'b0;
          data_mode = 1'b0;
          pins = pins & ~cur_masks.cmd_mask;
        end else if (prefix_alive[PAT_MLDP] && link_up && !data_mode) begin
          data_mode = 1'b1;
          pins = pins | cur_masks.cmd_mask;
        end else if ((prefix_alive[PAT_CMD] || prefix_alive[PAT_END]) && link_up && data_mode) begin
          data_mode = 1'b0;
          pins = pins & ~cur_masks.cmd_mask;
        end else if (prefix_alive[PAT_ON] && link_up && data_mode) begin
          pins = pins | led_bits_for_digit(on_digit_seen);
        end else if (prefix_alive[PAT_OFF]) begin
          pins = pins & ~led_bits_for_digit(off_digit_seen);
        end
      end
    end else begin
      // The line is full. This byte is dropped, even a CR or LF, and the next
      // byte starts a fresh line.
      line_fill = '0;
    end
    res.pin_state = pins;
    res.is_connected = link_up;
    res.in_data_mode = data_mode;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offers one byte and blocks until the block takes it. Valid stays high
  // after the transfer so that a following call can present the next byte in
  // the same step. Whoever advances time without sending lowers it first.
  task automatic send_byte(input logic [7:0] value);
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= value;
    do @(posedge clk); while (!rx_ch.ready);
    expected_pin_reports.push_back(decode_rx_byte(value));
    sent_count++;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Sends the first keep_len bytes of a text. With mix_case set, each letter
  // is sent in lower case by chance. The byte at corrupt_at, if that is a
  // valid position, is replaced by a random byte.
  task automatic send_text(input string text, input bit mix_case, input int keep_len,
                           input int corrupt_at);
    logic [7:0] ch;
    int         i;
    for (i = 0; i < keep_len; i++) begin
      ch = text[i];
      if (mix_case && ch >= "A" && ch <= "Z" && $urandom_range(0, 1) == 1) ch = ch + 8'd32;
      if (i == corrupt_at) ch = $urandom_range(0, 255);
      send_byte(ch);
    end
  endtask

  task automatic send_line(input string text, input logic [7:0] ending);
    send_text(text, 1'b0, text.len(), -1);
    send_byte(ending);
  endtask

  // Most lines are real commands with random case, digits, trailing junk and
  // the odd corrupted byte. The rest are cut-off commands, raw noise and
  // lines that run past the line length.
  task automatic send_random_line();
    int    pick;
    int    k;
    int    corrupt_at;
    bit    mix_case;
    string body;
    mix_case = $urandom_range(0, 1);
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      if (pick < 10)      k = PAT_CONNECTED;
      else if (pick < 17) k = PAT_CONN_END;
      else if (pick < 27) k = PAT_MLDP;
      else if (pick < 34) k = PAT_CMD;
      else if (pick < 41) k = PAT_END;
      else if (pick < 62) k = PAT_ON;
      else                k = PAT_OFF;
      body = line_pattern[k];
      corrupt_at = -1;
      if ($urandom_range(0, 9) == 0) corrupt_at = $urandom_range(0, body.len() - 1);
      send_text(body, mix_case, body.len(), corrupt_at);
      if (k == PAT_ON || k == PAT_OFF) begin
        if ($urandom_range(0, 4) != 0) send_byte(CHAR_ONE + $urandom_range(0, 2));
        else send_byte($urandom_range(0, 255));
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) send_byte($urandom_range(32, 126));
      end
    end else if (pick < 88) begin
      body = line_pattern[$urandom_range(0, PAT_COUNT - 1)];
      send_text(body, mix_case, $urandom_range(1, body.len() - 1), -1);
    end else if (pick < 94) begin
      repeat ($urandom_range(1, 24)) send_byte($urandom_range(0, 255));
    end else begin
      repeat ($urandom_range(LINE_LENGTH - 1, LINE_LENGTH + 4)) send_byte($urandom_range(32, 126));
    end
    // Now and then the ending is left out and the next line runs on.
    if ($urandom_range(0, 19) != 0) begin
      if ($urandom_range(0, 1) == 0) send_byte(CHAR_CR);
      else send_byte(CHAR_LF);
    end
  endtask

  // Stops offering bytes and waits until every owed result has come, plus a
  // settling wait of SETTLE_CYCLES for anything still inside the block.
  task automatic wait_drained();
    rx_ch.valid <= 1'b0;
    while (expected_pin_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Register port
  // --------------------------------------------------------------------------

  // A setup phase, an access phase that completes when pready is high, and
  // an idle phase so that back-to-back accesses never assign psel twice in
  // one step. The upper data bits are random and must be ignored.
  task automatic apb_write(input logic [1:0] reg_idx, input logic [7:0] value);
    logic [31:0] junk;
    junk = $urandom;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= {junk[31:8], value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (reg_idx)
      REG_CMD_MASK: cur_masks.cmd_mask = value;
      REG_LED_ONE:  cur_masks.led_one_bits = value;
      REG_LED_TWO:  cur_masks.led_two_bits = value;
      default:      cur_masks.led_three_bits = value;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Reads a register back and compares its low byte with our copy.
  task automatic apb_read_check(input logic [1:0] reg_idx);
    logic [7:0] want;
    case (reg_idx)
      REG_CMD_MASK: want = cur_masks.cmd_mask;
      REG_LED_ONE:  want = cur_masks.led_one_bits;
      REG_LED_TWO:  want = cur_masks.led_two_bits;
      default:      want = cur_masks.led_three_bits;
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {reg_idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== want) begin
      error_count++;
      $display("%0t: register %0d readback expected %02h actual %02h",
               $time, reg_idx, want, prdata[7:0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Masks change only while the block is idle, then each one is read back.
  task automatic program_masks(input logic [7:0] cmd_bits, input logic [7:0] one_bits,
                               input logic [7:0] two_bits, input logic [7:0] three_bits);
    wait_drained();
    apb_write(REG_CMD_MASK, cmd_bits);
    apb_write(REG_LED_ONE, one_bits);
    apb_write(REG_LED_TWO, two_bits);
    apb_write(REG_LED_THREE, three_bits);
    apb_read_check(REG_CMD_MASK);
    apb_read_check(REG_LED_ONE);
    apb_read_check(REG_LED_TWO);
    apb_read_check(REG_LED_THREE);
  endtask

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------

  task automatic check_field(input string field_name, input int want, input int got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s expected %0h actual %0h", $time, field_name, want, got);
    end
  endtask

  // Takes each result transfer, compares it with the oldest expectation and
  // drives ready. Ready drops for random bursts, and for one long hold when
  // the backpressure test asks for it by bumping hold_requests.
  initial begin : result_monitor
    int      stall_left;
    int      hold_left;
    int      holds_seen;
    result_t got;
    result_t want;
    stall_left = 0;
    hold_left = 0;
    holds_seen = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        got.pin_state = res_ch.pin_state;
        got.is_connected = res_ch.is_connected;
        got.in_data_mode = res_ch.in_data_mode;
        got.line_done = res_ch.line_done;
        if (expected_pin_reports.size() == 0) begin
          error_count++;
          $display("%0t: result with nothing expected, actual %p", $time, got);
        end else begin
          want = expected_pin_reports.pop_front();
          check_field("pin_state", want.pin_state, got.pin_state);
          check_field("is_connected", want.is_connected, got.is_connected);
          check_field("in_data_mode", want.in_data_mode, got.in_data_mode);
          check_field("line_done", want.line_done, got.line_done);
        end
      end
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left == 0 && stall_left == 0 && sink_idle_on && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 15);
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // The run ends in failure if no transfer happens for too long on any port.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) || (psel && penable))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Walks through every command with the masks as they come out of reset,
  // including the cases where a command is not allowed in the current mode,
  // short lines, a bad LED digit and the extremes of the byte range.
  task automatic test_commands_at_reset();
    send_line("MLDP", CHAR_CR);          // Not connected, so nothing happens.
    send_line("ON,LED1", CHAR_CR);       // Not allowed, and OFF cannot match.
    send_line("CONNECTED", CHAR_LF);
    send_text("on,led1", 1'b0, 7, -1);   // Lower case must fold to a match.
    send_byte(CHAR_CR);
    send_line("ON,LED3", CHAR_CR);
    send_line("ON,LED9", CHAR_CR);       // Bad digit ends the search.
    send_line("ON,LED", CHAR_CR);        // The digit slot holds the CR.
    send_line("CMD", CHAR_CR);
    send_line("ON,LED2", CHAR_LF);       // Out of data mode, nothing happens.
    send_line("MLDP", CHAR_CR);
    send_line("END", CHAR_LF);
    send_line("OFF,LED1", CHAR_CR);      // Allowed in any mode.
    send_line("CONNECTIO", CHAR_CR);     // Matches neither CONNECTED nor CONNECTION END.
    send_line("CONNECTION END", CHAR_CR);
    send_line("OFF,LED3", CHAR_LF);
    // Byte range extremes and both edges of the folding range.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(FOLD_LOW - 8'd1);
    send_byte(FOLD_LOW);
    send_byte(FOLD_HIGH);
    send_byte(FOLD_HIGH + 8'd1);
    send_byte(CHAR_LF);
    send_byte(CHAR_CR);                  // An empty line matches nothing.
  endtask

  // Writes every mask at both extremes and checks the command and LED pins
  // with masks that overlap, with masks that are empty and with masks on separate bits.
  task automatic test_mask_registers();
    program_masks(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_line("CONNECTED", CHAR_CR);
    send_line("ON,LED2", CHAR_CR);
    send_line("OFF,LED1", CHAR_LF);
    program_masks(8'h00, 8'h00, 8'h00, 8'h00);
    send_line("ON,LED3", CHAR_CR);
    send_line("CONNECTION END", CHAR_CR);
    program_masks(8'h80, 8'h40, 8'h20, 8'h10);
    send_line("CONNECTED", CHAR_LF);
    send_line("ON,LED1", CHAR_CR);
    send_line("ON,LED3", CHAR_CR);
  endtask

  // A line of exactly the longest length still ends normally. One byte more
  // and the ending is dropped, so the next line starts clean.
  task automatic test_line_overflow();
    send_text("CONNECTEDzzzzzzzzz", 1'b0, LINE_LENGTH - 2, -1);
    send_byte(CHAR_CR);
    send_text("OFF,LED1ZZZZZZZZZZZ", 1'b0, LINE_LENGTH - 1, -1);
    send_byte(CHAR_LF);                  // Dropped, the line restarts.
    send_line("OFF,LED3", CHAR_CR);
    send_line("CONNECTION END", CHAR_CR);
  endtask

  // The receiver holds off while the sender keeps offering bytes back to
  // back, so the block fills up and stalls its input. Afterwards the sender
  // pauses until every owed result has come.
  task automatic test_result_backpressure();
    bit saved_idle;
    saved_idle = src_idle_on;
    src_idle_on = 1'b0;
    hold_requests++;
    send_line("CONNECTED", CHAR_CR);
    send_line("ON,LED2", CHAR_CR);
    repeat (12) send_byte($urandom_range(0, 255));
    send_byte(CHAR_LF);
    src_idle_on = saved_idle;
    wait_drained();
  endtask

  // Random lines in several phases, each with its own set of masks.
  task automatic test_random_lines();
    int phase;
    int goal;
    goal = sent_count;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       program_masks(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        1:       program_masks(8'h00, 8'h00, 8'h00, 8'h00);
        default: program_masks($urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255), $urandom_range(0, 255));
      endcase
      goal += PHASE_ITEMS;
      while (sent_count < goal) send_random_line();
    end
  endtask

  // The last part runs at full rate with no idling on either side.
  task automatic test_steady_stream();
    int goal;
    program_masks(CMD_MASK_RST, LED_ONE_RST, LED_TWO_RST, LED_THREE_RST);
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    goal = sent_count + PHASE_ITEMS;
    while (sent_count < goal) send_random_line();
  endtask

  initial begin
    rst <= 1'b1;
    rx_ch.valid <= 1'b0;
    rx_ch.rx_byte <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_commands_at_reset();
    test_mask_registers();
    test_line_overflow();
    test_result_backpressure();
    test_random_lines();
    test_steady_stream();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_pin_reports.size() != 0) begin
      error_count += expected_pin_reports.size();
      $display("%0t: %0d results never arrived", $time, expected_pin_reports.size());
    end
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
